>>> src/avgpwm_pkg.sv
// Package for the averaged converter to PWM block: payload types, stage control,
// register indexes and reset values. No dependencies.
`default_nettype none

package avgpwm_pkg;

	// Fixed field widths
	localparam int IN_SAMPLE_W = 10;
	localparam int DUTY_W      = 8;
	localparam int AVG_W       = 10;
	localparam int CFG_W       = 10;
	localparam int CFG_IDX_W   = 2;

	// Operation codes
	localparam logic OP_TICK   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEAD_LOW  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEAD_HIGH = 2'd3;

	// Register reset values
	localparam logic [DUTY_W-1:0] MAX_DUTY_RST  = 8'd80;
	localparam logic [DUTY_W-1:0] PERIOD_RST    = 8'd250;
	localparam logic [CFG_W-1:0]  DEAD_LOW_RST  = 10'd51;
	localparam logic [CFG_W-1:0]  DEAD_HIGH_RST = 10'd972;

	// Result queue depth, also the bound on outstanding beats
	localparam int OUTQ_DEPTH = 8;

	typedef struct packed {
		logic                   operation;
		logic [IN_SAMPLE_W-1:0] sample;
	} avgpwm_in_t;

	typedef struct packed {
		logic              pwm_level;
		logic [DUTY_W-1:0] duty;
		logic [AVG_W-1:0]  average;
	} avgpwm_out_t;

	// Per-stage control: beat present, beat is a sample
	typedef struct packed {
		logic vld;
		logic smp;
	} avgpwm_ctl_t;

endpackage

`default_nettype wire

>>> src/avgpwm_window.sv
// Sample window: circular sample memory with valid bits, prefetched read of the
// slot being replaced, and the running sum. Depends on avgpwm_pkg.
`default_nettype none

module avgpwm_window
	import avgpwm_pkg::*;
#(
	parameter int WINDOW      = 50,
	parameter int SAMPLE_BITS = 10,
	parameter int SUM_W       = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire avgpwm_ctl_t            ctl_s1,
	input  wire logic [SAMPLE_BITS-1:0] sample_s1,
	output avgpwm_ctl_t                 ctl_s2,
	output logic [SUM_W-1:0]            sum
);

	localparam int WIN_AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam logic [WIN_AW-1:0] LAST_POS = WIN_AW'(WINDOW - 1);

	logic [SAMPLE_BITS-1:0] win_mem [WINDOW];
	logic [WINDOW-1:0]      win_vld_q;
	logic [WIN_AW-1:0]      wpos_q;
	logic [WIN_AW-1:0]      wpos_nxt;
	logic [WIN_AW-1:0]      rd_addr;
	logic [SAMPLE_BITS-1:0] rd_q;
	logic                   rd_vld_q;
	logic                   byp_q;
	logic [SAMPLE_BITS-1:0] byp_data_q;
	logic [SAMPLE_BITS-1:0] old_smp;
	logic [SUM_W-1:0]       sum_q;
	logic                   smp_now;

	assign smp_now  = ctl_s1.vld & ctl_s1.smp;
	assign wpos_nxt = (wpos_q == LAST_POS) ? '0 : wpos_q + WIN_AW'(1);

	// prefetch the slot the next sample will replace
	assign rd_addr = smp_now ? wpos_nxt : wpos_q;

	// value leaving the window: bypass, stored entry, or zero if never written
	always_comb begin
		if (byp_q) begin
			old_smp = byp_data_q;
		end else if (rd_vld_q) begin
			old_smp = rd_q;
		end else begin
			old_smp = '0;
		end
	end

	// memory array, no reset
	always_ff @(posedge clk) begin
		if (smp_now) begin
			win_mem[wpos_q] <= sample_s1;
		end
		rd_q       <= win_mem[rd_addr];
		byp_data_q <= sample_s1;
	end

	// control state and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_vld_q <= '0;
			wpos_q    <= '0;
			rd_vld_q  <= 1'b0;
			byp_q     <= 1'b0;
			sum_q     <= '0;
			ctl_s2    <= '0;
		end else begin
			ctl_s2   <= ctl_s1;
			rd_vld_q <= win_vld_q[rd_addr];
			byp_q    <= smp_now && (wpos_nxt == wpos_q);
			if (smp_now) begin
				win_vld_q[wpos_q] <= 1'b1;
				wpos_q            <= wpos_nxt;
				sum_q             <= sum_q - SUM_W'(old_smp) + SUM_W'(sample_s1);
			end
		end
	end

	// sum_q always reflects the beat now in stage 2
	assign sum = sum_q;

endmodule

`default_nettype wire

>>> src/avgpwm_duty.sv
// Average, duty mapping and PWM counter: pipeline stages 3 and 4 after the window.
// Depends on avgpwm_pkg.
`default_nettype none

module avgpwm_duty
	import avgpwm_pkg::*;
#(
	parameter int WINDOW      = 50,
	parameter int SAMPLE_BITS = 10,
	parameter int SUM_W       = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire avgpwm_ctl_t       ctl_s2,
	input  wire logic [SUM_W-1:0]  sum,
	input  wire logic [DUTY_W-1:0] max_duty,
	input  wire logic [DUTY_W-1:0] period_count,
	input  wire logic [CFG_W-1:0]  dead_low,
	input  wire logic [CFG_W-1:0]  dead_high,
	output logic                   push,
	output avgpwm_out_t            push_data
);

	localparam int SB     = SAMPLE_BITS;
	localparam int FULL   = (1 << SB) - 1;
	localparam int LOG_W  = $clog2(WINDOW);
	// floor(sum / WINDOW) == (sum * DIV_M) >> DIV_K for every sum < 2^SUM_W
	localparam int DIV_K  = SUM_W + LOG_W;
	localparam int M_W    = SUM_W + 1;
	localparam longint unsigned DIV_M_L = ((64'd1 << DIV_K) + WINDOW - 1) / WINDOW;
	localparam logic [M_W-1:0] DIV_M = M_W'(DIV_M_L);
	localparam int P_W    = SUM_W + M_W;
	localparam int CMP_W  = (SB > CFG_W) ? SB : CFG_W;
	localparam int PR_W   = SB + DUTY_W;

	avgpwm_ctl_t       ctl_s3;
	avgpwm_ctl_t       ctl_s4;
	logic [P_W-1:0]    recip_prod;
	logic [SB-1:0]     avg_s3;
	logic [SB-1:0]     avg_s4;
	logic [DUTY_W-1:0] cnt_q;
	logic [DUTY_W-1:0] cnt_inc;
	logic [DUTY_W-1:0] cnt_nxt;
	logic [DUTY_W-1:0] cnt_s3;
	logic [DUTY_W-1:0] cnt_s4;
	logic [PR_W-1:0]   prod_s4;
	logic              low_s4;
	logic              high_s4;
	logic [DUTY_W-1:0] max_s4;
	logic [DUTY_W-1:0] q0;
	logic [SB:0]       rem;
	logic [DUTY_W-1:0] scaled;
	logic [DUTY_W-1:0] duty_new;
	logic [DUTY_W-1:0] duty_cur;
	logic [DUTY_W-1:0] duty_q;

	// stage 3: average by reciprocal multiply, tick counter
	assign recip_prod = P_W'(sum) * P_W'(DIV_M);
	assign cnt_inc    = cnt_q + DUTY_W'(1);
	assign cnt_nxt    = (cnt_inc >= period_count) ? '0 : cnt_inc;

	always_ff @(posedge clk) begin
		avg_s3  <= recip_prod[DIV_K +: SB];
		cnt_s3  <= ctl_s2.smp ? cnt_q : cnt_nxt;
		prod_s4 <= PR_W'(avg_s3) * PR_W'(max_duty);
		low_s4  <= CMP_W'(avg_s3) <= CMP_W'(dead_low);
		high_s4 <= CMP_W'(avg_s3) >= CMP_W'(dead_high);
		max_s4  <= max_duty;
		avg_s4  <= avg_s3;
		cnt_s4  <= cnt_s3;
	end

	// stage 4 output: divide by full scale, x = q0*2^SB + r gives rem = r + q0 < 2*FULL
	assign q0     = prod_s4[SB +: DUTY_W];
	assign rem    = (SB+1)'(prod_s4[SB-1:0]) + (SB+1)'(q0);
	assign scaled = (rem >= (SB+1)'(FULL)) ? q0 + DUTY_W'(1) : q0;

	// dead band, low test first
	always_comb begin
		if (low_s4) begin
			duty_new = '0;
		end else if (high_s4) begin
			duty_new = max_s4;
		end else begin
			duty_new = scaled;
		end
	end

	assign duty_cur = ctl_s4.smp ? duty_new : duty_q;

	assign push                = ctl_s4.vld;
	assign push_data.pwm_level = cnt_s4 < duty_cur;
	assign push_data.duty      = duty_cur;
	assign push_data.average   = AVG_W'(avg_s4);

	// control, counter and duty state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			cnt_q  <= '0;
			duty_q <= '0;
		end else begin
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			if (ctl_s2.vld && !ctl_s2.smp) begin
				cnt_q <= cnt_nxt;
			end
			if (ctl_s4.vld) begin
				duty_q <= duty_cur;
			end
		end
	end

endmodule

`default_nettype wire

>>> src/avgpwm_outq.sv
// Result queue with credit count: bounds outstanding beats so the pipeline never
// stalls. Depends on avgpwm_pkg.
`default_nettype none

module avgpwm_outq
	import avgpwm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        take,
	output logic             room,
	input  wire logic        push,
	input  wire avgpwm_out_t push_data,
	output logic             result_valid,
	input  wire logic        result_ready,
	output avgpwm_out_t      result
);

	localparam int AW = $clog2(OUTQ_DEPTH);
	localparam int CW = $clog2(OUTQ_DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(OUTQ_DEPTH - 1);

	avgpwm_out_t   q_mem [OUTQ_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] credit_q;
	logic          pop;

	assign result_valid = fill_q != '0;
	assign result       = q_mem[rd_ptr_q];
	assign pop          = result_valid & result_ready;
	assign room         = credit_q < CW'(OUTQ_DEPTH);

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= push_data;
		end
	end

	// pointers, fill and credit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
			credit_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + AW'(1);
			end
			fill_q   <= fill_q + CW'(push) - CW'(pop);
			credit_q <= credit_q + CW'(take) - CW'(pop);
		end
	end

endmodule

`default_nettype wire

>>> src/averaged_adc_to_pwm_top.sv
// Top level of the averaged converter to PWM block: config registers, input
// stage, window, duty pipeline and result queue. Depends on avgpwm_pkg.
//
//  channel  | signals                           | beat
//  ---------+-----------------------------------+------------------------------
//  item     | item_valid, item_ready, item      | tick or sample (avgpwm_in_t)
//  result   | result_valid, result_ready, result| level, duty, average
//  config   | cfg_we, cfg_index, cfg_wdata      | one register write
//
// One item per cycle. A result passes the input stage, window/sum, average and
// duty registers before it enters the queue. The 8-entry result queue bounds
// outstanding items; item_ready drops only when eight taken items have not yet
// left as results, so full rate holds while results are taken at once.
// Reset clears the window valid bits, sum, counter, duty and queue at once.
`default_nettype none

module averaged_adc_to_pwm_top
	import avgpwm_pkg::*;
#(
	parameter int WINDOW      = 50,
	parameter int SAMPLE_BITS = 10
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	output logic                      item_ready,
	input  wire avgpwm_in_t           item,
	output logic                      result_valid,
	input  wire logic                 result_ready,
	output avgpwm_out_t               result,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata
);

	localparam int FULL    = (1 << SAMPLE_BITS) - 1;
	localparam int SUM_MAX = WINDOW * FULL;
	localparam int SUM_W   = $clog2(SUM_MAX + 1);

	logic [DUTY_W-1:0]      max_duty_q;
	logic [DUTY_W-1:0]      period_q;
	logic [CFG_W-1:0]       dead_low_q;
	logic [CFG_W-1:0]       dead_high_q;
	logic                   take;
	avgpwm_ctl_t            ctl_s1;
	avgpwm_ctl_t            ctl_s2;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic [SUM_W-1:0]       sum;
	logic                   push;
	avgpwm_out_t            push_data;

	assign take = item_valid & item_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_duty_q  <= MAX_DUTY_RST;
			period_q    <= PERIOD_RST;
			dead_low_q  <= DEAD_LOW_RST;
			dead_high_q <= DEAD_HIGH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_DUTY:  max_duty_q  <= cfg_wdata[DUTY_W-1:0];
				REG_PERIOD:    period_q    <= cfg_wdata[DUTY_W-1:0];
				REG_DEAD_LOW:  dead_low_q  <= cfg_wdata;
				REG_DEAD_HIGH: dead_high_q <= cfg_wdata;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.vld <= take;
			ctl_s1.smp <= item.operation == OP_SAMPLE;
		end
	end

	// sample payload, high bits beyond the converter width dropped
	always_ff @(posedge clk) begin
		if (take) begin
			sample_s1 <= SAMPLE_BITS'(item.sample);
		end
	end

	avgpwm_window #(
		.WINDOW      (WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS),
		.SUM_W       (SUM_W)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s1    (ctl_s1),
		.sample_s1 (sample_s1),
		.ctl_s2    (ctl_s2),
		.sum       (sum)
	);

	avgpwm_duty #(
		.WINDOW      (WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS),
		.SUM_W       (SUM_W)
	) u_duty (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl_s2       (ctl_s2),
		.sum          (sum),
		.max_duty     (max_duty_q),
		.period_count (period_q),
		.dead_low     (dead_low_q),
		.dead_high    (dead_high_q),
		.push         (push),
		.push_data    (push_data)
	);

	avgpwm_outq u_outq (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.room         (item_ready),
		.push         (push),
		.push_data    (push_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// every beat in the input stage reaches the queue through the window and stages 3 and 4
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s1.vld |-> ##3 push)
		else $error("beat lost in duty pipeline");

	// running sum never exceeds a full window at full scale
	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		sum <= SUM_W'(SUM_MAX))
		else $error("running sum out of range");

	// pin can only be high with a nonzero duty
	a_level_duty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (!result.pwm_level || result.duty != '0))
		else $error("pwm level high with zero duty");

endmodule

`default_nettype wire
